[design/clce_pkg.sv]
// Shared types and codes for the circular list cursor engine.
`default_nettype none

package clce_pkg;

  typedef enum logic [2:0] {
    FN_INS_AFTER  = 3'd0,
    FN_INS_BEFORE = 3'd1,
    FN_DELETE     = 3'd2,
    FN_NEXT       = 3'd3,
    FN_PREV       = 3'd4,
    FN_READ       = 3'd5,
    FN_CLEAR      = 3'd6
  } func_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DATA_BITS  = 32;
  localparam int unsigned COUNT_BITS = 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD1,
    S_WR0,
    S_WR1
  } seq_state_t;

  // decoded operation, held for the life of one request
  typedef struct packed {
    logic ins;
    logic after;
    logic del;
    logic mv_next;
    logic mv_prev;
    logic rd;
    logic clr;
    logic act;        // operation is carried out: list not empty, or a node to insert
    logic from_free;  // new node comes off the free chain
    logic first;      // insert into an empty list
    logic multi;      // more than one element present
  } op_t;

endpackage

`default_nettype wire

[design/circular_list_cursor_engine.sv]
// Top level of the circular list cursor engine.
// Holds one circular doubly linked list of values in a pool of POOL_NODES nodes, with a
// cursor on the current node. A request is taken in S_IDLE, where the cursor's links and
// value (or the free chain head's link) are read; S_RD1 does the second read (the cursor's
// next link, or the value of the node moved to); S_WR0 and S_WR1 write, since each link
// memory has a single write port and a request may need two link updates. The result sits
// in an output register, so a new request is taken while the previous result still waits.
// Link and value memories need no clearing after reset: nodes are handed out by a bump
// counter and only allocated nodes are ever read.
`default_nettype none

module circular_list_cursor_engine
  import clce_pkg::*;
#(
  parameter int unsigned POOL_NODES = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire logic [2:0]                   func,
  input  wire logic signed [DATA_BITS-1:0]  value,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output logic [1:0]                        status,
  output logic signed [DATA_BITS-1:0]       current_value,
  output logic [COUNT_BITS-1:0]             element_count
);

  localparam int unsigned LW = $clog2(POOL_NODES);

  logic                  nx_we, pv_we, vl_we;
  logic [LW-1:0]         nx_waddr, nx_wdata, nx_raddr, nx_rdata;
  logic [LW-1:0]         pv_waddr, pv_wdata, pv_raddr, pv_rdata;
  logic [LW-1:0]         vl_waddr, vl_raddr;
  logic [VALUE_BITS-1:0] vl_wdata, vl_rdata;
  logic                  res_valid, res_ready;
  logic [1:0]            res_status;
  logic [DATA_BITS-1:0]  res_value;
  logic [COUNT_BITS-1:0] res_count;

  clce_seq #(
    .POOL_NODES (POOL_NODES),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_func   (func),
    .req_value  (value),
    .nx_we      (nx_we),
    .nx_waddr   (nx_waddr),
    .nx_wdata   (nx_wdata),
    .nx_raddr   (nx_raddr),
    .nx_rdata   (nx_rdata),
    .pv_we      (pv_we),
    .pv_waddr   (pv_waddr),
    .pv_wdata   (pv_wdata),
    .pv_raddr   (pv_raddr),
    .pv_rdata   (pv_rdata),
    .vl_we      (vl_we),
    .vl_waddr   (vl_waddr),
    .vl_wdata   (vl_wdata),
    .vl_raddr   (vl_raddr),
    .vl_rdata   (vl_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_value  (res_value),
    .res_count  (res_count)
  );

  clce_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_next_link (
    .clk   (clk),
    .we    (nx_we),
    .waddr (nx_waddr),
    .wdata (nx_wdata),
    .raddr (nx_raddr),
    .rdata (nx_rdata)
  );

  clce_ram #(.WIDTH(LW), .DEPTH(POOL_NODES)) u_prev_link (
    .clk   (clk),
    .we    (pv_we),
    .waddr (pv_waddr),
    .wdata (pv_wdata),
    .raddr (pv_raddr),
    .rdata (pv_rdata)
  );

  clce_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_node_value (
    .clk   (clk),
    .we    (vl_we),
    .waddr (vl_waddr),
    .wdata (vl_wdata),
    .raddr (vl_raddr),
    .rdata (vl_rdata)
  );

  // output register
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      status        <= res_status;
      current_value <= res_value;
      element_count <= res_count;
    end
  end

endmodule

`default_nettype wire

[design/clce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module clce_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[design/clce_seq.sv]
// Request sequencer: list registers, memory accesses and link updates.
`default_nettype none

module clce_seq
  import clce_pkg::*;
#(
  parameter int unsigned POOL_NODES = 64,
  parameter int unsigned VALUE_BITS = 32,
  parameter int unsigned LW         = $clog2(POOL_NODES),
  parameter int unsigned CW         = $clog2(POOL_NODES + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   req_valid,
  output logic                        req_stall,
  input  wire logic [2:0]             req_func,
  input  wire logic signed [31:0]     req_value,
  // next link memory
  output logic                        nx_we,
  output logic [LW-1:0]               nx_waddr,
  output logic [LW-1:0]               nx_wdata,
  output logic [LW-1:0]               nx_raddr,
  input  wire logic [LW-1:0]          nx_rdata,
  // prev link memory
  output logic                        pv_we,
  output logic [LW-1:0]               pv_waddr,
  output logic [LW-1:0]               pv_wdata,
  output logic [LW-1:0]               pv_raddr,
  input  wire logic [LW-1:0]          pv_rdata,
  // value memory
  output logic                        vl_we,
  output logic [LW-1:0]               vl_waddr,
  output logic [VALUE_BITS-1:0]       vl_wdata,
  output logic [LW-1:0]               vl_raddr,
  input  wire logic [VALUE_BITS-1:0]  vl_rdata,
  // result
  output logic                        res_valid,
  input  wire logic                   res_ready,
  output logic [1:0]                  res_status,
  output logic [DATA_BITS-1:0]        res_value,
  output logic [COUNT_BITS-1:0]       res_count
);

  seq_state_t state, state_next;

  logic [LW-1:0]         cursor;
  logic [CW-1:0]         live_count;
  logic [LW-1:0]         free_head;
  logic [CW-1:0]         used;

  op_t                   op, op_d;
  logic [1:0]            status_d;
  logic [LW-1:0]         node, node_d;
  logic [VALUE_BITS-1:0] value_q;
  logic [LW-1:0]         next_q0;
  logic [LW-1:0]         prev_q;
  logic [VALUE_BITS-1:0] val_q0;
  logic [CW-1:0]         count_after;
  logic [63:0]           value_wide;
  logic                  accept;
  logic                  advance;
  logic                  list_empty;
  logic                  can_bump;

  function automatic logic [DATA_BITS-1:0] val_out(input logic [VALUE_BITS-1:0] v);
    logic [63:0] w;
    w = 64'($signed(v));
    return w[DATA_BITS-1:0];
  endfunction

  assign req_stall  = rst || (state != S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign res_valid  = (state == S_WR1);
  assign advance    = (state == S_WR1) && res_ready;
  assign value_wide = 64'(req_value);
  assign list_empty = (live_count == '0);
  assign can_bump   = (used < CW'(POOL_NODES));

  // request decode
  always_comb begin
    op_d           = '0;
    status_d       = ST_OK;
    op_d.from_free = (used > live_count);
    op_d.first     = list_empty;
    op_d.multi     = (live_count > CW'(1));
    node_d         = op_d.from_free ? free_head : used[LW-1:0];
    unique case (func_t'(req_func))
      FN_INS_AFTER, FN_INS_BEFORE: begin
        op_d.ins   = 1'b1;
        op_d.after = (func_t'(req_func) == FN_INS_AFTER);
        op_d.act   = op_d.from_free || can_bump;
        status_d   = op_d.act ? ST_OK : ST_FULL;
      end
      FN_DELETE, FN_NEXT, FN_PREV, FN_READ: begin
        op_d.del     = (func_t'(req_func) == FN_DELETE);
        op_d.mv_next = (func_t'(req_func) == FN_NEXT);
        op_d.mv_prev = (func_t'(req_func) == FN_PREV);
        op_d.rd      = (func_t'(req_func) == FN_READ);
        op_d.act     = !list_empty;
        status_d     = list_empty ? ST_EMPTY : ST_OK;
      end
      FN_CLEAR: begin
        op_d.clr = 1'b1;
        op_d.act = !list_empty;
      end
      default: begin
      end
    endcase
  end

  // state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (accept) state_next = S_RD1;
      S_RD1:   state_next = S_WR0;
      S_WR0:   state_next = S_WR1;
      S_WR1:   if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // read addresses: first reads at acceptance, second read in S_RD1
  always_comb begin
    nx_raddr = (state == S_IDLE && op_d.ins) ? free_head : cursor;
    pv_raddr = cursor;
    vl_raddr = cursor;
    if (state == S_RD1) begin
      vl_raddr = op.mv_next ? nx_rdata : pv_rdata;
    end
  end

  // link and value writes, in S_WR0 and S_WR1
  always_comb begin
    nx_we    = 1'b0;
    nx_waddr = node;
    nx_wdata = node;
    pv_we    = 1'b0;
    pv_waddr = node;
    pv_wdata = node;
    vl_we    = 1'b0;
    vl_waddr = node;
    vl_wdata = value_q;
    if (op.act && state == S_WR0) begin
      if (op.ins) begin
        vl_we = 1'b1;
        nx_we = 1'b1;
        pv_we = 1'b1;
        if (op.first) begin
          nx_wdata = node;
          pv_wdata = node;
        end else if (op.after) begin
          // nx_rdata holds next_link[cursor] here
          nx_wdata = nx_rdata;
          pv_waddr = nx_rdata;
          pv_wdata = node;
        end else begin
          nx_wdata = cursor;
          pv_wdata = prev_q;
        end
      end else if (op.del && op.multi) begin
        nx_we    = 1'b1;
        nx_waddr = prev_q;
        nx_wdata = next_q0;
        pv_we    = 1'b1;
        pv_waddr = next_q0;
        pv_wdata = prev_q;
      end else if (op.clr) begin
        nx_we    = 1'b1;
        nx_waddr = prev_q;
        nx_wdata = free_head;
      end
    end else if (op.act && state == S_WR1) begin
      if (op.ins && !op.first) begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        if (op.after) begin
          nx_waddr = cursor;
          nx_wdata = node;
          pv_waddr = node;
          pv_wdata = cursor;
        end else begin
          nx_waddr = prev_q;
          nx_wdata = node;
          pv_waddr = cursor;
          pv_wdata = node;
        end
      end else if (op.del) begin
        // freed node goes on top of the free chain
        nx_we    = 1'b1;
        nx_waddr = cursor;
        nx_wdata = free_head;
      end
    end
  end

  always_comb begin
    count_after = live_count;
    if (op.act) begin
      if (op.ins) begin
        count_after = live_count + CW'(1);
      end else if (op.del) begin
        count_after = live_count - CW'(1);
      end else if (op.clr) begin
        count_after = '0;
      end
    end
  end

  assign res_count = COUNT_BITS'(count_after);

  // request payload and captured read data
  always_ff @(posedge clk) begin
    if (accept) begin
      op         <= op_d;
      node       <= node_d;
      res_status <= status_d;
      value_q    <= value_wide[VALUE_BITS-1:0];
    end
    if (state == S_RD1) begin
      next_q0 <= nx_rdata;
      prev_q  <= pv_rdata;
      val_q0  <= vl_rdata;
    end
    if (state == S_WR0) begin
      if (op.act && (op.del || op.rd)) begin
        res_value <= val_out(val_q0);
      end else if (op.act && (op.mv_next || op.mv_prev)) begin
        res_value <= val_out(vl_rdata);
      end else begin
        res_value <= '0;
      end
    end
  end

  // list registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor     <= '0;
      live_count <= '0;
      free_head  <= '0;
      used       <= '0;
    end else if (advance && op.act) begin
      live_count <= count_after;
      if (op.ins) begin
        if (op.from_free) begin
          free_head <= next_q0;
        end else begin
          used <= used + CW'(1);
        end
        if (op.first) begin
          cursor <= node;
        end
      end else if (op.del) begin
        free_head <= cursor;
        if (op.multi) begin
          cursor <= next_q0;
        end
      end else if (op.mv_next) begin
        cursor <= next_q0;
      end else if (op.mv_prev) begin
        cursor <= prev_q;
      end else if (op.clr) begin
        free_head <= cursor;
      end
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the circular list cursor engine.
`timescale 1ns / 1ps

module testbench;
  import clce_pkg::*;

  localparam int unsigned POOL       = 64;
  localparam int unsigned RAND_ITEMS = 1500;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned CALM_LO    = 3000;
  localparam int unsigned CALM_HI    = 5000;
  localparam logic [2:0]  FN_UNUSED  = 3'd7;

  typedef logic [5:0] node_t;

  typedef struct {
    logic [2:0]         fn;
    logic signed [31:0] v;
  } list_req_t;

  typedef struct {
    logic [1:0]         status;
    logic signed [31:0] data;
    logic [6:0]         count;
  } list_rsp_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [2:0]         func = 3'd0;
  logic signed [31:0] value = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] current_value;
  logic [6:0]         element_count;

  // predicted list state
  node_t              link_next [POOL];
  node_t              link_prev [POOL];
  logic signed [31:0] node_val [POOL];
  node_t              cursor = '0;
  logic [6:0]         live_count = '0;
  node_t              free_head = '0;
  logic [6:0]         ever_used = '0;

  list_req_t pending_reqs [$];
  list_rsp_t expected_rsps [$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        req_taken = 1'b0;

  circular_list_cursor_engine u_dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .func          (func),
    .value         (value),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .status        (status),
    .current_value (current_value),
    .element_count (element_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one request to the predicted list and return its response
  function automatic list_rsp_t apply_request(logic [2:0] fn, logic signed [31:0] v);
    list_rsp_t r;
    node_t     n, c, p, nb;
    r.status = ST_OK;
    r.data   = '0;
    case (fn)
      FN_INS_AFTER, FN_INS_BEFORE: begin
        n = '0;
        if (ever_used > live_count) begin
          n = free_head;
          free_head = link_next[n];
        end else if (ever_used < 7'(POOL)) begin
          n = ever_used[5:0];
          ever_used = ever_used + 7'd1;
        end else begin
          r.status = ST_FULL;
        end
        if (r.status == ST_OK) begin
          node_val[n] = v;
          if (live_count == 0) begin
            link_next[n] = n;
            link_prev[n] = n;
            cursor = n;
          end else if (fn == FN_INS_AFTER) begin
            nb = link_next[cursor];
            link_next[n] = nb;
            link_prev[n] = cursor;
            link_prev[nb] = n;
            link_next[cursor] = n;
          end else begin
            nb = link_prev[cursor];
            link_next[n] = cursor;
            link_prev[n] = nb;
            link_next[nb] = n;
            link_prev[cursor] = n;
          end
          live_count = live_count + 7'd1;
        end
      end
      FN_DELETE, FN_NEXT, FN_PREV, FN_READ: begin
        if (live_count == 0) begin
          r.status = ST_EMPTY;
        end else if (fn == FN_DELETE) begin
          c = cursor;
          r.data = node_val[c];
          if (live_count > 1) begin
            p  = link_prev[c];
            nb = link_next[c];
            link_next[p] = nb;
            link_prev[nb] = p;
            cursor = nb;
          end
          link_next[c] = free_head;
          free_head = c;
          live_count = live_count - 7'd1;
        end else begin
          if (fn == FN_NEXT) cursor = link_next[cursor];
          else if (fn == FN_PREV) cursor = link_prev[cursor];
          r.data = node_val[cursor];
        end
      end
      FN_CLEAR: begin
        // whole ring spliced onto the free chain
        if (live_count > 0) begin
          p = link_prev[cursor];
          link_next[p] = free_head;
          free_head = cursor;
          live_count = '0;
        end
      end
      default: ;
    endcase
    r.count = live_count;
    return r;
  endfunction

  function automatic bit take_idle();
    if (cycle_count >= CALM_LO && cycle_count < CALM_HI) return 1'b0;
    return $urandom_range(99) < 32;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(11))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sh0000_0000;
      3: return 32'shffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_req(logic [2:0] fn, logic signed [31:0] v);
    list_req_t q;
    q.fn = fn;
    q.v  = v;
    pending_reqs.push_back(q);
  endtask

  task automatic report(string field, logic [31:0] want, logic [31:0] got);
    $display("mismatch on %s at cycle %0d: expected %0h, got %0h",
             field, cycle_count, want, got);
    mismatches++;
  endtask

  // request driver and response stall
  always @(negedge clk) begin
    list_req_t q;
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      if (!req_valid || req_taken) begin
        if (pending_reqs.size() > 0 && !take_idle()) begin
          q = pending_reqs.pop_front();
          req_valid <= 1'b1;
          func      <= q.fn;
          value     <= q.v;
        end else begin
          req_valid <= 1'b0;
        end
      end
      rsp_stall <= take_idle();
    end
  end

  // monitor: predict on request, check on response
  always @(posedge clk) begin
    list_rsp_t want;
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench NOT OK");
      $finish;
    end else if (rst) begin
      req_taken = 1'b0;
    end else begin
      req_taken = req_valid && !req_stall;
      if (req_taken) expected_rsps.push_back(apply_request(func, value));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          report("unexpected response", '0, 32'({status, element_count}));
        end else begin
          want = expected_rsps.pop_front();
          if (status !== want.status)
            report("status", 32'(want.status), 32'(status));
          if (current_value !== want.data)
            report("current_value", want.data, current_value);
          if (element_count !== want.count)
            report("element_count", 32'(want.count), 32'(element_count));
        end
      end
    end
  end

  initial begin
    int          n;
    int          len;
    int          mode;
    int          roll;
    int          ins_pct;
    int          del_pct;
    int          clr_pct;
    logic [2:0]  fn;

    // directed: empty-list cases, unused code, ring of one, extremes, clear
    add_req(FN_DELETE, 32'sh1234_5678);
    add_req(FN_NEXT, '0);
    add_req(FN_PREV, '0);
    add_req(FN_READ, '0);
    add_req(FN_UNUSED, 32'shffff_ffff);
    add_req(FN_CLEAR, '0);
    add_req(FN_INS_AFTER, 32'sh7fff_ffff);
    add_req(FN_DELETE, '0);
    add_req(FN_INS_BEFORE, 32'sh8000_0000);
    add_req(FN_INS_AFTER, 32'shffff_ffff);
    add_req(FN_INS_BEFORE, 32'sh0000_0000);
    add_req(FN_NEXT, '0);
    add_req(FN_PREV, '0);
    add_req(FN_READ, '0);
    add_req(FN_DELETE, '0);
    add_req(FN_CLEAR, '0);
    add_req(FN_READ, '0);
    add_req(FN_INS_AFTER, 32'sh5555_5555);
    add_req(FN_INS_BEFORE, 32'shaaaa_aaaa);
    add_req(FN_PREV, '0);
    add_req(FN_UNUSED, '0);
    add_req(FN_DELETE, '0);

    // random phases: fill-heavy phases push toward a full pool, drain-heavy ones toward an empty list
    n = 0;
    while (n < RAND_ITEMS) begin
      mode = $urandom_range(2);
      len  = $urandom_range(40, 200);
      case (mode)
        0: begin ins_pct = 72; del_pct = 10; clr_pct = 0; end
        1: begin ins_pct = 20; del_pct = 50; clr_pct = 1; end
        default: begin ins_pct = 40; del_pct = 30; clr_pct = 2; end
      endcase
      for (int k = 0; k < len; k++) begin
        roll = $urandom_range(99);
        if (roll < clr_pct) fn = FN_CLEAR;
        else if (roll < clr_pct + 1) fn = FN_UNUSED;
        else if (roll < clr_pct + 1 + ins_pct)
          fn = $urandom_range(1) ? FN_INS_AFTER : FN_INS_BEFORE;
        else if (roll < clr_pct + 1 + ins_pct + del_pct) fn = FN_DELETE;
        else begin
          case ($urandom_range(2))
            0: fn = FN_NEXT;
            1: fn = FN_PREV;
            default: fn = FN_READ;
          endcase
        end
        add_req(fn, pick_value());
        n++;
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

[filelist.f]
design/clce_pkg.sv
design/clce_ram.sv
design/clce_seq.sv
design/circular_list_cursor_engine.sv
dv/testbench.sv
